[rtl/osp_pkg.sv]
package osp_pkg;

    localparam int BufferBytes = 256;
    localparam int CountWidth  = $clog2(BufferBytes + 1);
    localparam int FieldAlign  = 4;
    localparam int AlignWidth  = $clog2(FieldAlign);

    localparam logic [7:0] FramingReset = 8'hC0;
    localparam logic [7:0] SlashChar    = 8'h2F;
    localparam logic [7:0] CommaChar    = 8'h2C;

    typedef enum logic [2:0] {
        PH_SEEK      = 3'd0,
        PH_SLASH     = 3'd1,
        PH_ADDR      = 3'd2,
        PH_PAD_ADDR  = 3'd3,
        PH_COMMA     = 3'd4,
        PH_TYPES     = 3'd5,
        PH_PAD_TYPES = 3'd6,
        PH_VALUES    = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_SKIP    = 3'd0,
        ROLE_ADDR    = 3'd1,
        ROLE_TYPE    = 3'd2,
        ROLE_VALUE   = 3'd3,
        ROLE_PAD     = 3'd4,
        ROLE_FRAMING = 3'd5
    } t_role;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_FRAMING  = 3'd1,
        ERR_NO_SLASH    = 3'd2,
        ERR_ADDR_OPEN   = 3'd3,
        ERR_NO_COMMA    = 3'd4,
        ERR_TYPES_OPEN  = 3'd5,
        ERR_NO_VALUES   = 3'd6
    } t_err;

    typedef struct packed {
        t_phase                  phase;
        logic [AlignWidth-1:0]   align;
        logic [CountWidth-1:0]   count;
    } t_state;

    typedef struct packed {
        t_role                   role;
        logic                    done;
        t_err                    err;
        logic [CountWidth-1:0]   count;
    } t_result;

endpackage

[rtl/osp_step.sv]
module osp_step (
    input  osp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_eob,
    input  logic [7:0]       i_framing_byte,
    output osp_pkg::t_state  o_next,
    output osp_pkg::t_result o_result
);
    import osp_pkg::*;

    logic [CountWidth-1:0] w_cnt;
    logic [AlignWidth-1:0] w_align_inc;
    logic                  w_done;
    t_err                  w_err;
    t_role                 w_role;
    t_state                w_next;

    assign w_cnt = (i_state.count < CountWidth'(BufferBytes)) ?
                   i_state.count + 1'b1 : CountWidth'(BufferBytes);
    assign w_align_inc = i_state.align + 1'b1;

    always_comb begin
        w_next = i_state;
        w_role = ROLE_SKIP;
        w_err  = ERR_NONE;
        w_done = 1'b0;
        unique case (i_state.phase)
            PH_SEEK: begin
                if (i_byte == i_framing_byte) begin
                    w_role       = ROLE_FRAMING;
                    w_next.phase = PH_SLASH;
                    if (i_eob) w_err = ERR_NO_SLASH;
                end else if (i_eob) begin
                    w_err = ERR_NO_FRAMING;
                end
            end
            PH_SLASH: begin
                if (i_byte == SlashChar) begin
                    w_role       = ROLE_ADDR;
                    w_next.align = AlignWidth'(1);
                    w_next.phase = PH_ADDR;
                    if (i_eob) w_err = ERR_ADDR_OPEN;
                end else begin
                    w_err = ERR_NO_SLASH;
                end
            end
            PH_ADDR: begin
                w_next.align = w_align_inc;
                if (i_byte != '0) begin
                    w_role = ROLE_ADDR;
                    if (i_eob) w_err = ERR_ADDR_OPEN;
                end else begin
                    w_role       = ROLE_PAD;
                    w_next.phase = (w_align_inc != '0) ? PH_PAD_ADDR : PH_COMMA;
                    if (i_eob) w_err = ERR_NO_COMMA;
                end
            end
            PH_PAD_ADDR: begin
                w_role       = ROLE_PAD;
                w_next.align = w_align_inc;
                if (w_align_inc == '0) w_next.phase = PH_COMMA;
                if (i_eob) w_err = ERR_NO_COMMA;
            end
            PH_COMMA: begin
                if (i_byte == CommaChar) begin
                    w_role       = ROLE_TYPE;
                    w_next.align = AlignWidth'(1);
                    w_next.phase = PH_TYPES;
                    if (i_eob) w_err = ERR_TYPES_OPEN;
                end else begin
                    w_err = ERR_NO_COMMA;
                end
            end
            PH_TYPES: begin
                w_next.align = w_align_inc;
                if (i_byte != '0) begin
                    w_role = ROLE_TYPE;
                    if (i_eob) w_err = ERR_TYPES_OPEN;
                end else begin
                    w_role       = ROLE_PAD;
                    w_next.phase = (w_align_inc != '0) ? PH_PAD_TYPES : PH_VALUES;
                    if (i_eob) w_err = ERR_NO_VALUES;
                end
            end
            PH_PAD_TYPES: begin
                w_role       = ROLE_PAD;
                w_next.align = w_align_inc;
                if (w_align_inc == '0) w_next.phase = PH_VALUES;
                if (i_eob) w_err = ERR_NO_VALUES;
            end
            PH_VALUES: begin
                if (i_byte == i_framing_byte) begin
                    w_role = ROLE_FRAMING;
                    w_done = 1'b1;
                end else begin
                    w_role = ROLE_VALUE;
                    if (i_eob) w_done = 1'b1;
                end
            end
            default: begin
                w_next.phase = PH_SEEK;
            end
        endcase

        if (w_done || (w_err != ERR_NONE)) begin
            w_next.phase = PH_SEEK;
            w_next.align = '0;
            w_next.count = '0;
        end else begin
            w_next.count = w_cnt;
        end
    end

    assign o_next          = w_next;
    assign o_result.role   = w_role;
    assign o_result.done   = w_done;
    assign o_result.err    = w_err;
    assign o_result.count  = w_cnt;

endmodule

[rtl/osc_slip_message_parser.sv]
// An accepted item passes through the input register and then the output register before it appears on the output.
// Throughput: one item per cycle while the receiver takes results; the parse state updates once per byte.
// An input register and an output register let one further input be accepted while a
// result waits to be taken.
// Reset (synchronous, active low) returns the parser to the search for the framing
// byte, clears the byte count and the valid flags of both pipeline registers, and restores framing byte 0xC0.
module osc_slip_message_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [7:0]                      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_end_of_buffer,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_byte_role,
    output logic                            o_message_done,
    output logic [2:0]                      o_error_code,
    output logic [osp_pkg::CountWidth-1:0]  o_consumed_count
);
    import osp_pkg::*;

    logic [7:0] r_framing_byte;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;
    logic       r_out_valid;
    t_result    r_result;
    t_state     r_state;

    t_state     n_state;
    t_result    w_result;
    logic       w_advance;

    osp_step u_step (
        .i_state        (r_state),
        .i_byte         (r_in_byte),
        .i_eob          (r_in_eob),
        .i_framing_byte (r_framing_byte),
        .o_next         (n_state),
        .o_result       (w_result)
    );

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_framing_byte <= FramingReset;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state.phase  <= PH_SEEK;
            r_state.align  <= '0;
            r_state.count  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_framing_byte <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eob  <= i_end_of_buffer;
        end
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_role      = r_result.role;
    assign o_message_done   = r_result.done;
    assign o_error_code     = r_result.err;
    assign o_consumed_count = r_result.count;

`ifndef SYNTHESIS
    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (w_result.done || (w_result.err != ERR_NONE))
        |=> (r_state.phase == PH_SEEK) && (r_state.count == '0))
        else $error("parser did not return to search after a message end");

    a_done_excludes_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.done && (r_result.err != ERR_NONE)))
        else $error("completion and error reported together");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.count != '0)
                     && (r_result.count <= CountWidth'(BufferBytes)))
        else $error("consumed count out of range");

    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_SEEK) |-> (r_state.count != '0))
        else $error("frame in progress with zero consumed count");
`endif

endmodule

[sim/osc_slip_message_parser_tb.sv]
`timescale 1ns / 1ps

module osc_slip_message_parser_tb;
    import osp_pkg::*;

    class frame_scoreboard;
        logic [7:0]            framing;
        t_phase                phase;
        logic [AlignWidth-1:0] align;
        logic [CountWidth-1:0] count;
        t_result               pending_results[$];
        int                    fail_count;

        function new();
            framing = FramingReset;
            phase = PH_SEEK;
            align = '0;
            count = '0;
            fail_count = 0;
        endfunction

        function t_result parse_byte(input logic [7:0] b, input logic eob);
            t_result               r;
            t_phase                nxt;
            t_role                 role;
            t_err                  err;
            logic                  done;
            logic [CountWidth-1:0] cnt;
            cnt = (count < BufferBytes) ? count + 1'b1 : CountWidth'(BufferBytes);
            role = ROLE_SKIP;
            err = ERR_NONE;
            done = 1'b0;
            nxt = phase;
            case (phase)
                PH_SEEK: begin
                    if (b == framing) begin
                        role = ROLE_FRAMING;
                        nxt = PH_SLASH;
                        if (eob) err = ERR_NO_SLASH;
                    end else if (eob) begin
                        err = ERR_NO_FRAMING;
                    end
                end
                PH_SLASH: begin
                    if (b == SlashChar) begin
                        role = ROLE_ADDR;
                        align = AlignWidth'(1);
                        nxt = PH_ADDR;
                        if (eob) err = ERR_ADDR_OPEN;
                    end else begin
                        err = ERR_NO_SLASH;
                    end
                end
                PH_ADDR: begin
                    align = align + 1'b1;
                    if (b != 8'h00) begin
                        role = ROLE_ADDR;
                        if (eob) err = ERR_ADDR_OPEN;
                    end else begin
                        role = ROLE_PAD;
                        nxt = (align != 0) ? PH_PAD_ADDR : PH_COMMA;
                        if (eob) err = ERR_NO_COMMA;
                    end
                end
                PH_PAD_ADDR: begin
                    role = ROLE_PAD;
                    align = align + 1'b1;
                    if (align == 0) nxt = PH_COMMA;
                    if (eob) err = ERR_NO_COMMA;
                end
                PH_COMMA: begin
                    if (b == CommaChar) begin
                        role = ROLE_TYPE;
                        align = AlignWidth'(1);
                        nxt = PH_TYPES;
                        if (eob) err = ERR_TYPES_OPEN;
                    end else begin
                        err = ERR_NO_COMMA;
                    end
                end
                PH_TYPES: begin
                    align = align + 1'b1;
                    if (b != 8'h00) begin
                        role = ROLE_TYPE;
                        if (eob) err = ERR_TYPES_OPEN;
                    end else begin
                        role = ROLE_PAD;
                        nxt = (align != 0) ? PH_PAD_TYPES : PH_VALUES;
                        if (eob) err = ERR_NO_VALUES;
                    end
                end
                PH_PAD_TYPES: begin
                    role = ROLE_PAD;
                    align = align + 1'b1;
                    if (align == 0) nxt = PH_VALUES;
                    if (eob) err = ERR_NO_VALUES;
                end
                PH_VALUES: begin
                    if (b == framing) begin
                        role = ROLE_FRAMING;
                        done = 1'b1;
                    end else begin
                        role = ROLE_VALUE;
                        if (eob) done = 1'b1;
                    end
                end
            endcase
            if (done || err != ERR_NONE) begin
                phase = PH_SEEK;
                align = '0;
                count = '0;
            end else begin
                phase = nxt;
                count = cnt;
            end
            r.role = role;
            r.done = done;
            r.err = err;
            r.count = cnt;
            return r;
        endfunction

        function void note_byte(input logic [7:0] b, input logic eob);
            pending_results.push_back(parse_byte(b, eob));
        endfunction

        function void check_result(input logic [2:0] role, input logic done,
                                   input logic [2:0] err, input logic [CountWidth-1:0] cnt);
            t_result exp;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item pending, role %0d count %0d",
                         $time, role, cnt);
                fail_count++;
            end else begin
                exp = pending_results.pop_front();
                if (exp.role !== role) begin
                    $display("%0t: byte_role expected %0d actual %0d", $time, exp.role, role);
                    fail_count++;
                end
                if (exp.done !== done) begin
                    $display("%0t: message_done expected %0d actual %0d", $time, exp.done, done);
                    fail_count++;
                end
                if (exp.err !== err) begin
                    $display("%0t: error_code expected %0d actual %0d", $time, exp.err, err);
                    fail_count++;
                end
                if (exp.count !== cnt) begin
                    $display("%0t: consumed_count expected %0d actual %0d",
                             $time, exp.count, cnt);
                    fail_count++;
                end
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [7:0]            i_cfg_data = 8'h00;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  i_end_of_buffer = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [2:0]            o_byte_role;
    logic                  o_message_done;
    logic [2:0]            o_error_code;
    logic [CountWidth-1:0] o_consumed_count;

    frame_scoreboard parser = new();
    bit              idle_on = 1'b0;
    bit              hold_req = 1'b0;
    int              sent_items = 0;
    logic [7:0]      frame_q[$];
    int              comma_pos;

    osc_slip_message_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_buffer  (i_end_of_buffer),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_role      (o_byte_role),
        .o_message_done   (o_message_done),
        .o_error_code     (o_error_code),
        .o_consumed_count (o_consumed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            parser.check_result(o_byte_role, o_message_done, o_error_code, o_consumed_count);
        end
    end

    // The receiver alternates ready stretches with random stalls; a hold request
    // keeps it stalled long enough for the block to back up onto its input.
    initial begin
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (90) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eob);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parser.note_byte(b, eob);
        sent_items++;
    endtask

    task automatic wait_drained();
        while (parser.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_framing(input logic [7:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        parser.framing = value;
    endtask

    function automatic logic [7:0] non_framing();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == parser.framing) b = b ^ 8'h01;
        return b;
    endfunction

    task automatic build_frame(input int addr_len, input int type_len, input int val_len,
                               input bit close);
        logic [7:0] b;
        frame_q.delete();
        frame_q.push_back(parser.framing);
        frame_q.push_back(SlashChar);
        repeat (addr_len) begin
            if (parser.framing != 8'h00 && $urandom_range(0, 7) == 0) b = parser.framing;
            else b = 8'($urandom_range(1, 255));
            frame_q.push_back(b);
        end
        frame_q.push_back(8'h00);
        repeat ((FieldAlign - (addr_len + 2) % FieldAlign) % FieldAlign)
            frame_q.push_back(8'($urandom));
        comma_pos = frame_q.size();
        frame_q.push_back(CommaChar);
        repeat (type_len) frame_q.push_back(8'($urandom_range(1, 255)));
        frame_q.push_back(8'h00);
        repeat ((FieldAlign - (type_len + 2) % FieldAlign) % FieldAlign)
            frame_q.push_back(8'($urandom));
        repeat (val_len) frame_q.push_back(non_framing());
        if (close) frame_q.push_back(parser.framing);
    endtask

    task automatic send_frame(input int len, input bit eob_end);
        for (int i = 0; i < len; i++) send_item(frame_q[i], eob_end && i == len - 1);
    endtask

    task automatic random_sequence();
        int kind;
        int pos;
        bit close;
        kind = $urandom_range(0, 99);
        close = $urandom_range(0, 4) != 0;
        if (kind >= 90) begin
            repeat ($urandom_range(1, 6)) send_item(8'($urandom), $urandom_range(0, 2) == 0);
        end else begin
            build_frame($urandom_range(0, 9), $urandom_range(0, 5), $urandom_range(0, 10),
                        close);
            if (kind < 60) begin
                repeat ($urandom_range(0, 2)) send_item(non_framing(), 1'b0);
                send_frame(frame_q.size(), close ? $urandom_range(0, 5) == 0 : 1'b1);
            end else if (kind < 80) begin
                send_frame($urandom_range(1, frame_q.size()), 1'b1);
            end else begin
                pos = $urandom_range(0, 1) ? 1 : comma_pos;
                frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
                send_frame(frame_q.size(), $urandom_range(0, 1));
            end
        end
    endtask

    task automatic run_random(input int n_items);
        int start;
        start = sent_items;
        while (sent_items - start < n_items) random_sequence();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(FramingReset, 1'b1);
        send_item(FramingReset, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(FramingReset, 1'b0);
        send_item(SlashChar, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(CommaChar, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b1);
        send_item(FramingReset, 1'b0);
        send_item(SlashChar, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(FramingReset, 1'b0);
        send_item(SlashChar, 1'b0);
        send_item(FramingReset, 1'b1);

        // A long run with no buffer end drives the byte count into saturation.
        repeat (300) send_item(non_framing(), 1'b0);
        send_item(parser.framing, 1'b1);

        for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
            case (phase_idx)
                1: write_framing(8'h00);
                2: write_framing(8'hFF);
                3, 5: write_framing(8'($urandom));
                4: begin
                    write_framing(FramingReset);
                    hold_req = 1'b1;
                end
                default: ;
            endcase
            if (phase_idx == 5) idle_on = 1'b0;
            run_random(270);
            i_in_valid <= 1'b0;
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (parser.fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
